FILE: design/hrmq_pkg.sv
package hrmq_pkg;

  localparam int MAP_DIM   = 256;
  localparam int FRAC_BITS = 10;
  localparam int DIR_FRAC  = 12;
  localparam int IDX_W     = $clog2(MAP_DIM);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = MAP_DIM * MAP_DIM;
  localparam int ONE       = 1 << FRAC_BITS;

  // Field widths of the request and response.
  localparam int OP_W   = 2;
  localparam int CELL_W = 8;
  localparam int HGT_W  = 15;
  localparam int POS_W  = 22;
  localparam int DIR_W  = 14;
  localparam int T_W    = 21;
  localparam int ST_W   = 3;
  localparam int DIM_W  = 9;
  localparam int STEP_W = 13;
  localparam int CIDX_W = 2;

  // Shared multiplier operand widths.
  localparam int MA_W = 24;
  localparam int MB_W = 16;
  localparam int MP_W = MA_W + MB_W;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_RAY   = 2'd2;

  localparam logic [ST_W-1:0] ST_WRITTEN = 3'd0;
  localparam logic [ST_W-1:0] ST_HGT_OK  = 3'd1;
  localparam logic [ST_W-1:0] ST_HGT_OOR = 3'd2;
  localparam logic [ST_W-1:0] ST_HIT     = 3'd3;
  localparam logic [ST_W-1:0] ST_LEFT    = 3'd4;
  localparam logic [ST_W-1:0] ST_NO_HIT  = 3'd5;

  localparam logic [CIDX_W-1:0] REG_MAP_WIDTH   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MAP_HEIGHT  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_COARSE_STEP = 2'd2;
  localparam logic [CIDX_W-1:0] REG_FINE_STEP   = 2'd3;

  typedef struct packed {
    logic signed [MA_W-1:0] a;
    logic signed [MB_W-1:0] b;
  } mul_op_t;

endpackage

FILE: design/hrmq_if.sv
interface hrmq_req_if;
  logic valid;
  logic ready;
  logic [hrmq_pkg::OP_W-1:0]          op;
  logic [hrmq_pkg::CELL_W-1:0]        cell_x;
  logic [hrmq_pkg::CELL_W-1:0]        cell_z;
  logic [hrmq_pkg::HGT_W-1:0]         cell_height;
  logic signed [hrmq_pkg::POS_W-1:0]  pos_x;
  logic signed [hrmq_pkg::POS_W-1:0]  pos_y;
  logic signed [hrmq_pkg::POS_W-1:0]  pos_z;
  logic signed [hrmq_pkg::DIR_W-1:0]  dir_x;
  logic signed [hrmq_pkg::DIR_W-1:0]  dir_y;
  logic signed [hrmq_pkg::DIR_W-1:0]  dir_z;
  logic [hrmq_pkg::T_W-1:0]           t_near;
  logic [hrmq_pkg::T_W-1:0]           t_far;

  modport source (output valid, op, cell_x, cell_z, cell_height, pos_x, pos_y, pos_z,
                  dir_x, dir_y, dir_z, t_near, t_far, input ready);
  modport sink (input valid, op, cell_x, cell_z, cell_height, pos_x, pos_y, pos_z,
                dir_x, dir_y, dir_z, t_near, t_far, output ready);
endinterface

interface hrmq_rsp_if;
  logic valid;
  logic ready;
  logic [hrmq_pkg::ST_W-1:0]          status;
  logic signed [hrmq_pkg::POS_W-1:0]  hit_x;
  logic signed [hrmq_pkg::POS_W-1:0]  hit_y;
  logic signed [hrmq_pkg::POS_W-1:0]  hit_z;
  logic [hrmq_pkg::HGT_W-1:0]         height;

  modport source (output valid, status, hit_x, hit_y, hit_z, height, input ready);
  modport sink (input valid, status, hit_x, hit_y, hit_z, height, output ready);
endinterface

interface hrmq_cfg_if;
  logic valid;
  logic ready;
  logic [hrmq_pkg::CIDX_W-1:0] index;
  logic [hrmq_pkg::STEP_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/hrmq_mul.sv
module hrmq_mul (
  input  logic                             clk,
  input  hrmq_pkg::mul_op_t                op,
  output logic signed [hrmq_pkg::MP_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op.a * op.b;
  end

endmodule

FILE: design/heightfield_ray_march_query.sv
// Channel  Role    Moves
// -------  ------  ------------------------------------------------
// req      sink    one request: op, cell, position, direction, range
// rsp      source  one response: status, hit point, height
// cfg      sink    register write: index, data
//
// Cell writes, height queries and ray march samples all use one shared multiplier. A query
// off the grid reads no taps; a ray ends at the first sample that leaves the map.
// The ray sample count is set by the range and the steps, so it varies with data.
// Reset clears control state only; the height memory is not cleared.
// req is taken while a finished response still waits; the block then stalls at its end.
module heightfield_ray_march_query (
  input  logic                 clk,
  input  logic                 rst,
  hrmq_req_if.sink             req,
  hrmq_rsp_if.source           rsp,
  hrmq_cfg_if.sink             cfg
);

  localparam int PW  = 28;
  localparam int OW  = 23;
  localparam int TSW = 24;
  localparam int FW  = hrmq_pkg::FRAC_BITS;
  localparam int WTW = FW + 1;
  localparam int AW  = hrmq_pkg::ADDR_W;
  localparam int IW  = hrmq_pkg::IDX_W;
  localparam int ACW = hrmq_pkg::HGT_W + WTW;
  localparam int MA  = hrmq_pkg::MA_W;
  localparam int MB  = hrmq_pkg::MB_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WIDX  = 4'd1;
  localparam logic [3:0] S_WWR   = 4'd2;
  localparam logic [3:0] S_QIDX  = 4'd3;
  localparam logic [3:0] S_QRD   = 4'd4;
  localparam logic [3:0] S_QWT   = 4'd5;
  localparam logic [3:0] S_QACC  = 4'd6;
  localparam logic [3:0] S_RMX   = 4'd7;
  localparam logic [3:0] S_RMY   = 4'd8;
  localparam logic [3:0] S_RMZ   = 4'd9;
  localparam logic [3:0] S_RPZ   = 4'd10;
  localparam logic [3:0] S_RCHK  = 4'd11;
  localparam logic [3:0] S_RADDR = 4'd12;
  localparam logic [3:0] S_RCMP  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state;

  // Configuration registers.
  logic [hrmq_pkg::DIM_W-1:0]  map_width, map_height;
  logic [hrmq_pkg::STEP_W-1:0] coarse_step, fine_step;
  logic [hrmq_pkg::DIM_W-1:0]  w_c, h_c;
  logic [hrmq_pkg::STEP_W-1:0] cs_c, fs_c;
  logic [FW+hrmq_pkg::DIM_W-2:0] half_w, half_h;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width   <= hrmq_pkg::DIM_W'(256);
      map_height  <= hrmq_pkg::DIM_W'(256);
      coarse_step <= hrmq_pkg::STEP_W'(1024);
      fine_step   <= hrmq_pkg::STEP_W'(102);
    end else if (cfg.valid) begin
      case (cfg.index)
        hrmq_pkg::REG_MAP_WIDTH:   map_width   <= cfg.data[hrmq_pkg::DIM_W-1:0];
        hrmq_pkg::REG_MAP_HEIGHT:  map_height  <= cfg.data[hrmq_pkg::DIM_W-1:0];
        hrmq_pkg::REG_COARSE_STEP: coarse_step <= cfg.data;
        hrmq_pkg::REG_FINE_STEP:   fine_step   <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_c = (map_width < 9'd2) ? 9'd2 :
          (map_width > 9'(hrmq_pkg::MAP_DIM)) ? 9'(hrmq_pkg::MAP_DIM) : map_width;
    h_c = (map_height < 9'd2) ? 9'd2 :
          (map_height > 9'(hrmq_pkg::MAP_DIM)) ? 9'(hrmq_pkg::MAP_DIM) : map_height;
    cs_c = (coarse_step == 13'd0) ? 13'd1 : (coarse_step > 13'd4096) ? 13'd4096 : coarse_step;
    fs_c = (fine_step == 13'd0) ? 13'd1 : (fine_step > 13'd4096) ? 13'd4096 : fine_step;
    half_w = {w_c, {(FW-1){1'b0}}};
    half_h = {h_c, {(FW-1){1'b0}}};
  end

  // Working registers.
  logic [IW-1:0]  cz;
  // X index (the memory row) of the cell to write, held from the request.
  logic [IW-1:0]  cz_in;
  logic           wr_ok;
  logic [hrmq_pkg::HGT_W-1:0] wdata;
  logic [IW-1:0]  qx [3];
  logic [IW-1:0]  qz [3];
  logic [WTW-1:0] wt [3];
  logic [1:0]     k;
  logic [ACW-1:0] acc;
  logic signed [OW-1:0] ox, oy, oz;
  logic signed [hrmq_pkg::DIR_W-1:0] dx, dy, dz;
  logic signed [TSW-1:0] t;
  logic [hrmq_pkg::T_W-1:0] tf;
  logic [hrmq_pkg::STEP_W-1:0] step;
  logic backed;
  logic signed [PW-1:0] px, py, pz;

  // Pending result.
  logic [hrmq_pkg::ST_W-1:0] p_status;
  logic signed [hrmq_pkg::POS_W-1:0] p_hx, p_hy, p_hz;
  logic [hrmq_pkg::HGT_W-1:0] p_height;

  // The query result is taken from the accumulator once all three taps are in.
  logic [ACW-1:0] acc_rnd;
  logic [hrmq_pkg::HGT_W-1:0] q_height;

  assign acc_rnd  = acc + ACW'(hrmq_pkg::ONE / 2);
  assign q_height = acc_rnd[FW+hrmq_pkg::HGT_W-1:FW];

  // Shared multiplier.
  hrmq_pkg::mul_op_t mop;
  logic signed [hrmq_pkg::MP_W-1:0] prod;

  hrmq_mul u_mul (.clk(clk), .op(mop), .prod(prod));

  // Height memory.
  logic [hrmq_pkg::HGT_W-1:0] mem [hrmq_pkg::DEPTH];
  logic [hrmq_pkg::HGT_W-1:0] rd_data;
  logic [AW-1:0] addr;
  logic [IW-1:0] zsel;
  logic          mem_we;

  always_comb begin
    case (state)
      S_QRD:   zsel = qz[k];
      S_RADDR: zsel = pz[FW+IW-1:FW];
      default: zsel = cz;
    endcase
    addr   = prod[AW-1:0] + AW'(zsel);
    mem_we = (state == S_WWR) && wr_ok;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wdata;
    end
    rd_data <= mem[addr];
  end

  always_comb begin
    mop.a = '0;
    mop.b = '0;
    case (state)
      S_WIDX: begin
        mop.a = MA'(cz_in);
        mop.b = MB'(w_c);
      end
      S_QIDX: begin
        mop.a = MA'(qx[k]);
        mop.b = MB'(w_c);
      end
      S_QWT: begin
        mop.a = MA'(rd_data);
        mop.b = MB'(wt[k]);
      end
      S_RMX: begin
        mop.a = t;
        mop.b = MB'(dx);
      end
      S_RMY: begin
        mop.a = t;
        mop.b = MB'(dy);
      end
      S_RMZ: begin
        mop.a = t;
        mop.b = MB'(dz);
      end
      S_RCHK: begin
        mop.a = MA'(px[FW+IW-1:FW]);
        mop.b = MB'(w_c);
      end
      default: ;
    endcase
  end

  // Request decode for the query.
  logic signed [OW-1:0] tx, tz;
  logic [FW-1:0] fx, fz;
  logic [FW:0]   fsum;
  logic          q_oor, upper;
  logic signed [OW-FW-1:0] ix, iz;

  always_comb begin
    tx = OW'(req.pos_x) + OW'(signed'({1'b0, half_w}));
    tz = OW'(req.pos_z) + OW'(signed'({1'b0, half_h}));
    ix = tx[OW-1:FW];
    iz = tz[OW-1:FW];
    fx = tx[FW-1:0];
    fz = tz[FW-1:0];
    fsum = {1'b0, fx} + {1'b0, fz};
    q_oor = tx[OW-1] || tz[OW-1] ||
            (ix >= (OW-FW)'(w_c - 9'd1)) || (iz >= (OW-FW)'(h_c - 9'd1));
    upper = fsum > (FW+1)'(hrmq_pkg::ONE);
  end

  // March step update and sample tests.
  logic signed [TSW-1:0] t_new;
  logic hit, out_map;
  logic signed [PW-1:0] xmax, zmax;

  always_comb begin
    hit = py < signed'(PW'(rd_data));
    if (hit) begin
      t_new = t - TSW'(cs_c) + TSW'(fs_c);
    end else begin
      t_new = t + TSW'(step);
    end
    xmax = PW'({w_c - 9'd1, {FW{1'b0}}});
    zmax = PW'({h_c - 9'd1, {FW{1'b0}}});
    out_map = px[PW-1] || pz[PW-1] || (px > xmax) || (pz > zmax);
  end

  logic signed [PW-1:0] prod_sh;
  assign prod_sh = prod[hrmq_pkg::DIR_FRAC+PW-1:hrmq_pkg::DIR_FRAC];

  // In the done state, the response register loads when it is empty or being emptied this cycle.
  logic rsp_load;
  assign rsp_load = (state == S_DONE) && (!rsp.valid || rsp.ready);

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            p_hx     <= '0;
            p_hy     <= '0;
            p_hz     <= '0;
            p_height <= '0;
            case (req.op)
              hrmq_pkg::OP_WRITE: begin
                p_status <= hrmq_pkg::ST_WRITTEN;
                cz_in <= req.cell_x;
                cz    <= req.cell_z;
                wdata <= req.cell_height;
                wr_ok <= (9'(req.cell_x) < w_c) && (9'(req.cell_z) < h_c);
                state <= S_WIDX;
              end
              hrmq_pkg::OP_QUERY: begin
                if (q_oor) begin
                  p_status <= hrmq_pkg::ST_HGT_OOR;
                  state    <= S_DONE;
                end else begin
                  p_status <= hrmq_pkg::ST_HGT_OK;
                  k   <= 2'd0;
                  acc <= '0;
                  qx[1] <= IW'(ix) + IW'(1);
                  qz[1] <= IW'(iz);
                  qx[2] <= IW'(ix);
                  qz[2] <= IW'(iz) + IW'(1);
                  if (upper) begin
                    qx[0] <= IW'(ix) + IW'(1);
                    qz[0] <= IW'(iz) + IW'(1);
                    wt[0] <= WTW'(fsum - (FW+1)'(hrmq_pkg::ONE));
                    wt[1] <= WTW'(hrmq_pkg::ONE) - WTW'(fz);
                    wt[2] <= WTW'(hrmq_pkg::ONE) - WTW'(fx);
                  end else begin
                    qx[0] <= IW'(ix);
                    qz[0] <= IW'(iz);
                    wt[0] <= WTW'(hrmq_pkg::ONE) - WTW'(fsum);
                    wt[1] <= WTW'(fx);
                    wt[2] <= WTW'(fz);
                  end
                  state <= S_QIDX;
                end
              end
              hrmq_pkg::OP_RAY: begin
                p_status <= hrmq_pkg::ST_NO_HIT;
                ox     <= OW'(req.pos_x) + OW'(signed'({1'b0, half_w}));
                oy     <= OW'(req.pos_y);
                oz     <= OW'(req.pos_z) + OW'(signed'({1'b0, half_h}));
                dx     <= req.dir_x;
                dy     <= req.dir_y;
                dz     <= req.dir_z;
                t      <= TSW'(req.t_near);
                tf     <= req.t_far;
                step   <= cs_c;
                backed <= 1'b0;
                if (req.t_near < req.t_far) begin
                  state <= S_RMX;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                p_status <= hrmq_pkg::ST_WRITTEN;
                state    <= S_DONE;
              end
            endcase
          end
        end
        S_WIDX: state <= S_WWR;
        S_WWR:  state <= S_DONE;
        S_QIDX: state <= S_QRD;
        S_QRD:  state <= S_QWT;
        S_QWT:  state <= S_QACC;
        S_QACC: begin
          acc <= acc + prod[ACW-1:0];
          if (k == 2'd2) begin
            state <= S_DONE;
          end else begin
            k     <= k + 2'd1;
            state <= S_QIDX;
          end
        end
        S_RMX: state <= S_RMY;
        S_RMY: begin
          px    <= PW'(ox) + prod_sh;
          state <= S_RMZ;
        end
        S_RMZ: begin
          py    <= PW'(oy) + prod_sh;
          state <= S_RPZ;
        end
        S_RPZ: begin
          pz    <= PW'(oz) + prod_sh;
          state <= S_RCHK;
        end
        S_RCHK: begin
          if (out_map) begin
            p_status <= hrmq_pkg::ST_LEFT;
            state    <= S_DONE;
          end else begin
            state <= S_RADDR;
          end
        end
        S_RADDR: state <= S_RCMP;
        S_RCMP: begin
          if (hit && backed) begin
            p_status <= hrmq_pkg::ST_HIT;
            p_hx <= hrmq_pkg::POS_W'(px - PW'(half_w));
            p_hy <= (py > PW'(2097151)) ? 22'sh1FFFFF :
                    (py < -PW'(2097152)) ? -22'sh200000 : hrmq_pkg::POS_W'(py);
            p_hz <= hrmq_pkg::POS_W'(pz - PW'(half_h));
            state <= S_DONE;
          end else begin
            if (hit) begin
              backed <= 1'b1;
              step   <= fs_c;
            end
            t <= t_new;
            if (t_new < signed'(TSW'(tf))) begin
              state <= S_RMX;
            end else begin
              p_status <= hrmq_pkg::ST_NO_HIT;
              state    <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp.status <= p_status;
            rsp.hit_x  <= p_hx;
            rsp.hit_y  <= p_hy;
            rsp.hit_z  <= p_hz;
            rsp.height <= (p_status == hrmq_pkg::ST_HGT_OK) ? q_height : p_height;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/hrmq_check.sv
module hrmq_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [hrmq_pkg::ST_W-1:0]   status,
  input logic [hrmq_pkg::POS_W-1:0]  hit_x,
  input logic [hrmq_pkg::POS_W-1:0]  hit_y,
  input logic [hrmq_pkg::POS_W-1:0]  hit_z,
  input logic [hrmq_pkg::HGT_W-1:0]  height
);

  // A response waits until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
    else $error("response dropped or changed while stalled");

  // One request at a time: no new request right after one is taken.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= hrmq_pkg::ST_NO_HIT)
    else $error("status code out of range");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != hrmq_pkg::ST_HIT |-> hit_x == '0 && hit_y == '0 && hit_z == '0)
    else $error("hit point not zero without a hit");

  a_height_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != hrmq_pkg::ST_HGT_OK |-> height == '0)
    else $error("height not zero without a height result");

endmodule

bind heightfield_ray_march_query hrmq_check u_check (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .status(rsp.status), .hit_x(rsp.hit_x), .hit_y(rsp.hit_y), .hit_z(rsp.hit_z),
  .height(rsp.height)
);

FILE: dv/hrmq_tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [hrmq_pkg::OP_W-1:0] OP_NONE = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD = 400;
  localparam int RAND_PER_PHASE = 36;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_W [NUM_PHASES] = '{4, 2, 256, 2, 1, 8, 5, 12};
  localparam int PHASE_H [NUM_PHASES] = '{4, 2, 2, 256, 300, 6, 9, 8};
  localparam int PHASE_CS [NUM_PHASES] = '{1024, 4096, 1, 300, 0, 8191, 3, 512};
  localparam int PHASE_FS [NUM_PHASES] = '{102, 4096, 1, 50, 8191, 4000, 0, 64};
  localparam longint ONE = hrmq_pkg::ONE;

  typedef struct packed {
    logic [hrmq_pkg::OP_W-1:0]          op;
    logic [hrmq_pkg::CELL_W-1:0]        cell_x;
    logic [hrmq_pkg::CELL_W-1:0]        cell_z;
    logic [hrmq_pkg::HGT_W-1:0]         cell_height;
    logic signed [hrmq_pkg::POS_W-1:0]  pos_x;
    logic signed [hrmq_pkg::POS_W-1:0]  pos_y;
    logic signed [hrmq_pkg::POS_W-1:0]  pos_z;
    logic signed [hrmq_pkg::DIR_W-1:0]  dir_x;
    logic signed [hrmq_pkg::DIR_W-1:0]  dir_y;
    logic signed [hrmq_pkg::DIR_W-1:0]  dir_z;
    logic [hrmq_pkg::T_W-1:0]           t_near;
    logic [hrmq_pkg::T_W-1:0]           t_far;
  } query_t;

  typedef struct packed {
    logic [hrmq_pkg::ST_W-1:0]          status;
    logic signed [hrmq_pkg::POS_W-1:0]  hit_x;
    logic signed [hrmq_pkg::POS_W-1:0]  hit_y;
    logic signed [hrmq_pkg::POS_W-1:0]  hit_z;
    logic [hrmq_pkg::HGT_W-1:0]         height;
  } answer_t;

  logic clk;
  logic rst;

  hrmq_req_if req ();
  hrmq_rsp_if rsp ();
  hrmq_cfg_if cfg ();

  heightfield_ray_march_query dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  // Local copy of the terrain and the registers.
  logic [hrmq_pkg::HGT_W-1:0] terrain [hrmq_pkg::DEPTH];
  logic [hrmq_pkg::DIM_W-1:0] reg_w;
  logic [hrmq_pkg::DIM_W-1:0] reg_h;
  logic [hrmq_pkg::STEP_W-1:0] reg_cs;
  logic [hrmq_pkg::STEP_W-1:0] reg_fs;

  query_t pending_q [$];
  answer_t answers_q [$];
  query_t on_wire;
  int send_gap;
  int recv_wait;
  bit no_gaps;
  bit hold_request;
  int errors;
  int idle_cycles;

  always #1 clk = ~clk;

  function automatic longint clampl(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint eff_w();
    return clampl(longint'(reg_w), 2, hrmq_pkg::MAP_DIM);
  endfunction

  function automatic longint eff_h();
    return clampl(longint'(reg_h), 2, hrmq_pkg::MAP_DIM);
  endfunction

  function automatic longint eff_cs();
    return clampl(longint'(reg_cs), 1, 4096);
  endfunction

  function automatic longint eff_fs();
    return clampl(longint'(reg_fs), 1, 4096);
  endfunction

  function automatic longint terrain_at(longint x, longint z, longint w);
    longint i;
    i = x * w + z;
    if (i < 0 || i >= hrmq_pkg::DEPTH) return 0;
    return longint'(terrain[i]);
  endfunction

  function automatic answer_t march_or_lookup(query_t r);
    answer_t a;
    longint w, h, cs, fs, hw, hh, tx, tz, ix, iz, fx, fz, acc;
    longint ox, oy, oz, dx, dy, dz, t, tf, stp, px, py, pz;
    bit backed;
    w = eff_w();
    h = eff_h();
    cs = eff_cs();
    fs = eff_fs();
    hw = w * (ONE / 2);
    hh = h * (ONE / 2);
    a = '0;
    a.status = hrmq_pkg::ST_WRITTEN;
    case (r.op)
      hrmq_pkg::OP_WRITE: begin
        if (r.cell_x < w && r.cell_z < h)
          terrain[longint'(r.cell_x) * w + longint'(r.cell_z)] = r.cell_height;
      end
      hrmq_pkg::OP_QUERY: begin
        tx = longint'(r.pos_x) + hw;
        tz = longint'(r.pos_z) + hh;
        ix = tx >>> hrmq_pkg::FRAC_BITS;
        iz = tz >>> hrmq_pkg::FRAC_BITS;
        if (ix < 0 || iz < 0 || ix >= w - 1 || iz >= h - 1) begin
          a.status = hrmq_pkg::ST_HGT_OOR;
        end else begin
          fx = tx - ix * ONE;
          fz = tz - iz * ONE;
          if (fx + fz <= ONE)
            acc = terrain_at(ix, iz, w) * (ONE - fx - fz) + terrain_at(ix + 1, iz, w) * fx
                + terrain_at(ix, iz + 1, w) * fz;
          else
            acc = terrain_at(ix + 1, iz, w) * (ONE - fz)
                + terrain_at(ix + 1, iz + 1, w) * (fx + fz - ONE)
                + terrain_at(ix, iz + 1, w) * (ONE - fx);
          a.height = hrmq_pkg::HGT_W'((acc + ONE / 2) >>> hrmq_pkg::FRAC_BITS);
          a.status = hrmq_pkg::ST_HGT_OK;
        end
      end
      hrmq_pkg::OP_RAY: begin
        ox = longint'(r.pos_x) + hw;
        oy = longint'(r.pos_y);
        oz = longint'(r.pos_z) + hh;
        dx = longint'(r.dir_x);
        dy = longint'(r.dir_y);
        dz = longint'(r.dir_z);
        t = longint'(r.t_near);
        tf = longint'(r.t_far);
        stp = cs;
        backed = 0;
        a.status = hrmq_pkg::ST_NO_HIT;
        while (t < tf) begin
          px = ox + ((dx * t) >>> hrmq_pkg::DIR_FRAC);
          py = oy + ((dy * t) >>> hrmq_pkg::DIR_FRAC);
          pz = oz + ((dz * t) >>> hrmq_pkg::DIR_FRAC);
          if (px < 0 || pz < 0 || px > (w - 1) * ONE || pz > (h - 1) * ONE) begin
            a.status = hrmq_pkg::ST_LEFT;
            break;
          end
          if (py < terrain_at(px >>> hrmq_pkg::FRAC_BITS, pz >>> hrmq_pkg::FRAC_BITS, w))
          begin
            if (backed) begin
              a.status = hrmq_pkg::ST_HIT;
              a.hit_x = hrmq_pkg::POS_W'(clampl(px - hw, -2097152, 2097151));
              a.hit_y = hrmq_pkg::POS_W'(clampl(py, -2097152, 2097151));
              a.hit_z = hrmq_pkg::POS_W'(clampl(pz - hh, -2097152, 2097151));
              break;
            end
            backed = 1;
            t -= cs;
            stp = fs;
          end
          t += stp;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Driver: one request on the wire at a time, drawn gaps between requests.
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      send_gap <= 0;
    end else if (!(req.valid && !req.ready)) begin
      if (req.valid)
        answers_q.push_back(march_or_lookup(on_wire));
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        on_wire = pending_q.pop_front();
        req.op <= on_wire.op;
        req.cell_x <= on_wire.cell_x;
        req.cell_z <= on_wire.cell_z;
        req.cell_height <= on_wire.cell_height;
        req.pos_x <= on_wire.pos_x;
        req.pos_y <= on_wire.pos_y;
        req.pos_z <= on_wire.pos_z;
        req.dir_x <= on_wire.dir_x;
        req.dir_y <= on_wire.dir_y;
        req.dir_z <= on_wire.dir_z;
        req.t_near <= on_wire.t_near;
        req.t_far <= on_wire.t_far;
        req.valid <= 1'b1;
        send_gap <= no_gaps ? 0 : $urandom_range(0, 7);
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure and the check against the oldest expectation.
  always @(posedge clk) begin
    answer_t e;
    int w;
    if (rst) begin
      rsp.ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      w = recv_wait;
      if (rsp.valid && rsp.ready) begin
        if (answers_q.size() == 0) begin
          $display("%0t: response with nothing expected, got %0d %0d %0d %0d %0d", $time,
                   rsp.status, rsp.hit_x, rsp.hit_y, rsp.hit_z, rsp.height);
          errors++;
        end else begin
          e = answers_q.pop_front();
          if (e.status !== rsp.status || e.hit_x !== rsp.hit_x || e.hit_y !== rsp.hit_y ||
              e.hit_z !== rsp.hit_z || e.height !== rsp.height) begin
            $display("%0t: expected status %0d hit %0d %0d %0d height %0d", $time,
                     e.status, e.hit_x, e.hit_y, e.hit_z, e.height);
            $display("%0t: actual   status %0d hit %0d %0d %0d height %0d", $time,
                     rsp.status, rsp.hit_x, rsp.hit_y, rsp.hit_z, rsp.height);
            errors++;
          end
        end
        w = no_gaps ? 0 : $urandom_range(0, 7);
      end
      if (hold_request) begin
        hold_request = 0;
        w = LONG_HOLD;
      end
      if (w > 0) begin
        rsp.ready <= 1'b0;
        recv_wait <= w - 1;
      end else begin
        rsp.ready <= 1'b1;
        recv_wait <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("heightfield_ray_march_query test failed");
      $finish;
    end
  end

  task automatic write_reg(logic [hrmq_pkg::CIDX_W-1:0] idx,
                           logic [hrmq_pkg::STEP_W-1:0] value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      hrmq_pkg::REG_MAP_WIDTH: reg_w = value[hrmq_pkg::DIM_W-1:0];
      hrmq_pkg::REG_MAP_HEIGHT: reg_h = value[hrmq_pkg::DIM_W-1:0];
      hrmq_pkg::REG_COARSE_STEP: reg_cs = value;
      default: reg_fs = value;
    endcase
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_q.size() != 0 || req.valid || answers_q.size() != 0);
  endtask

  function automatic query_t noise();
    logic [191:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(query_t)-1:0];
  endfunction

  function automatic query_t cell_write(int x, int z, int hgt);
    query_t r;
    r = noise();
    r.op = hrmq_pkg::OP_WRITE;
    r.cell_x = hrmq_pkg::CELL_W'(x);
    r.cell_z = hrmq_pkg::CELL_W'(z);
    r.cell_height = hrmq_pkg::HGT_W'(hgt);
    return r;
  endfunction

  function automatic query_t height_query(longint gx, longint gz);
    query_t r;
    r = noise();
    r.op = hrmq_pkg::OP_QUERY;
    r.pos_x = hrmq_pkg::POS_W'(gx - eff_w() * (ONE / 2));
    r.pos_z = hrmq_pkg::POS_W'(gz - eff_h() * (ONE / 2));
    return r;
  endfunction

  // Ray with its origin in fixed-point grid coordinates; the far end of the range is clamped to 2097151.
  function automatic query_t ray(longint gx, longint y, longint gz, int dx, int dy, int dz,
                                 longint tn, longint span);
    query_t r;
    r = noise();
    r.op = hrmq_pkg::OP_RAY;
    r.pos_x = hrmq_pkg::POS_W'(gx - eff_w() * (ONE / 2));
    r.pos_y = hrmq_pkg::POS_W'(y);
    r.pos_z = hrmq_pkg::POS_W'(gz - eff_h() * (ONE / 2));
    r.dir_x = hrmq_pkg::DIR_W'(dx);
    r.dir_y = hrmq_pkg::DIR_W'(dy);
    r.dir_z = hrmq_pkg::DIR_W'(dz);
    r.t_near = hrmq_pkg::T_W'(tn);
    r.t_far = hrmq_pkg::T_W'(clampl(tn + span, 0, 2097151));
    return r;
  endfunction

  function automatic longint short_span();
    return longint'($urandom_range(0, 40)) * clampl(eff_cs(), 1, eff_fs());
  endfunction

  function automatic query_t random_request();
    query_t r;
    int pick;
    longint gxm, gzm, gx;
    gxm = (eff_w() - 1) * ONE;
    gzm = (eff_h() - 1) * ONE;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      r = cell_write(int'($urandom_range(0, 255) % (eff_w() + 2)),
                     int'($urandom_range(0, 255) % (eff_h() + 2)), $urandom_range(0, 32767));
    end else if (pick < 24) begin
      r = noise();
      r.op = OP_NONE;
    end else if (pick < 36) begin
      r = noise();
      r.op = hrmq_pkg::OP_QUERY;
    end else if (pick < 50) begin
      r = height_query($urandom_range(0, 32'(gxm + ONE - 1)),
                       $urandom_range(0, 32'(gzm + ONE - 1)));
    end else if (pick < 58) begin
      // Origin pushed off the map, everything else random.
      gx = longint'($urandom_range(0, 2097151)) + gxm + 1;
      r = ray(0, 0, 0, 0, 0, 0, $urandom_range(0, 2097151), short_span());
      r.pos_x = hrmq_pkg::POS_W'(($urandom_range(0, 1)) ? gx : -gx);
      r.pos_y = hrmq_pkg::POS_W'($urandom());
      r.pos_z = hrmq_pkg::POS_W'($urandom());
      r.dir_x = hrmq_pkg::DIR_W'($urandom());
      r.dir_y = hrmq_pkg::DIR_W'($urandom());
      r.dir_z = hrmq_pkg::DIR_W'($urandom());
      if ($urandom_range(0, 4) == 0) r.t_far = hrmq_pkg::T_W'($urandom_range(0, r.t_near));
    end else begin
      r = ray($urandom_range(0, 32'(gxm)), longint'($urandom_range(0, 40000)) - 5000,
              $urandom_range(0, 32'(gzm)), $urandom_range(0, 16383) - 8192,
              $urandom_range(0, 1) ? -$urandom_range(0, 8192) : $urandom_range(0, 16383) - 8192,
              $urandom_range(0, 16383) - 8192, $urandom_range(0, 4096), short_span());
    end
    return r;
  endfunction

  initial begin
    longint last_w, last_h;
    clk = 1'b0;
    rst = 1'b1;
    errors = 0;
    idle_cycles = 0;
    no_gaps = 0;
    hold_request = 0;
    req.valid = 1'b0;
    req.op = hrmq_pkg::OP_WRITE;
    req.cell_x = '0;
    req.cell_z = '0;
    req.cell_height = '0;
    req.pos_x = '0;
    req.pos_y = '0;
    req.pos_z = '0;
    req.dir_x = '0;
    req.dir_y = '0;
    req.dir_z = '0;
    req.t_near = '0;
    req.t_far = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = hrmq_pkg::REG_MAP_WIDTH;
    cfg.data = '0;
    reg_w = 9'd256;
    reg_h = 9'd256;
    reg_cs = 13'd1024;
    reg_fs = 13'd102;
    for (int i = 0; i < hrmq_pkg::DEPTH; i++) terrain[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: the grid is not filled, so only requests that read no cell.
    pending_q.push_back(cell_write(255, 255, 32767));
    pending_q.push_back(cell_write(0, 0, 0));
    pending_q.push_back(height_query(-1, 5));
    pending_q.push_back(height_query(255 * ONE, 5));
    pending_q.push_back(ray(-5000, 100, 0, 8191, 0, 0, 0, 2000));
    pending_q.push_back(ray(100, 100, 100, 0, -4096, 0, 700, 0));
    wait_drained();
    last_w = 256;
    last_h = 256;

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(hrmq_pkg::REG_MAP_WIDTH, hrmq_pkg::STEP_W'(PHASE_W[p]));
      write_reg(hrmq_pkg::REG_MAP_HEIGHT, hrmq_pkg::STEP_W'(PHASE_H[p]));
      write_reg(hrmq_pkg::REG_COARSE_STEP, hrmq_pkg::STEP_W'(PHASE_CS[p]));
      write_reg(hrmq_pkg::REG_FINE_STEP, hrmq_pkg::STEP_W'(PHASE_FS[p]));
      no_gaps = (p % 3 == 1);
      // A new stride scrambles the stored cells, so the whole map is written again.
      if (eff_w() != last_w || eff_h() != last_h) begin
        for (int x = 0; x < eff_w(); x++)
          for (int z = 0; z < eff_h(); z++)
            pending_q.push_back(cell_write(x, z, $urandom_range(0, 32767)));
        last_w = eff_w();
        last_h = eff_h();
      end
      if (p == 0) begin
        pending_q.push_back(cell_write(4, 1, 77));
        pending_q.push_back(cell_write(1, 4, 77));
        pending_q.push_back(height_query(0, 0));
        pending_q.push_back(height_query(ONE / 2, ONE / 2));
        pending_q.push_back(height_query(ONE + 900, 2 * ONE + 700));
        pending_q.push_back(height_query(3 * ONE - 1, 3 * ONE - 1));
        pending_q.push_back(height_query(3 * ONE, ONE));
        pending_q.push_back(height_query(-1, ONE));
        pending_q.push_back(ray(1500, 40000, 1500, 0, -4096, 0, 0, 50000));
        pending_q.push_back(ray(1500, -2097152, 1500, 0, -8192, 0, 0, 5000));
        pending_q.push_back(ray(1500, -100, 1500, 0, 0, 0, 0, 5000));
        pending_q.push_back(ray(0, 40000, 0, 8191, -8192, 8191, 0, 60000));
        pending_q.push_back(ray(3 * ONE, 40000, 3 * ONE, -8192, 0, -8192, 0, 60000));
        pending_q.push_back(ray(1500, 40000, 1500, 0, 8191, 0, 0, 30000));
        pending_q.push_back(ray(1500, 100, 1500, 0, 0, 0, 2097151, 0));
        pending_q.push_back(ray(1500, 100, 1500, 0, 0, 0, 9000, -3000));
        pending_q.push_back(ray(ONE, 0, ONE, 100, 0, 0, 2097151 - 100, 100));
        pending_q.push_back(noise());
        pending_q[$].op = OP_NONE;
        wait_drained();
      end
      if (p == 2) hold_request = 1;
      for (int i = 0; i < RAND_PER_PHASE; i++) pending_q.push_back(random_request());
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("heightfield_ray_march_query test passed");
    else
      $display("heightfield_ray_march_query test failed");
    $finish;
  end

endmodule

FILE: files.f
design/hrmq_pkg.sv
design/hrmq_if.sv
design/hrmq_mul.sv
design/heightfield_ray_march_query.sv
design/hrmq_check.sv
dv/hrmq_tb.sv
